[hw/rtl/psq_pkg.sv]
// shared types and constants for the prime square test block
`timescale 1ns / 1ps
`default_nettype none
package psq_pkg;

   localparam int VALUE_W = 32;
   localparam logic [VALUE_W-1:0] ROOT_BIT_INIT = VALUE_W'(1) << (VALUE_W - 2);

   typedef struct packed {
      logic fill_step;
      logic scan_init;
      logic scan_read;
      logic scan_next;
      logic mark_init;
      logic mark_step;
      logic root_load;
      logic root_step;
      logic look_read;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic fill_last;
      logic scan_end;
      logic mark_end;
      logic root_last;
      logic map_bit;
   } status_type;

endpackage
`default_nettype wire

[hw/rtl/psq_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module psq_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/psq_datapath.sv]
// sieve counters, iterative square root, prime map and result register
`timescale 1ns / 1ps
`default_nettype none
module psq_datapath #(
   parameter int ROOT_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire psq_pkg::cmd_type               cmd,
   input  wire logic [psq_pkg::VALUE_W-1:0]    value,
   output psq_pkg::status_type                 sts,
   output logic                                is_prime_square
);

   localparam int VW  = psq_pkg::VALUE_W;
   localparam int IW  = (ROOT_BITS + 1) / 2 + 1;
   localparam int SQW = 2 * IW;
   localparam int JW  = ROOT_BITS + 1;

   logic [ROOT_BITS-1:0] fill_addr_ff, fill_addr_in;
   logic [IW-1:0]        i_ff, i_in;
   logic [JW-1:0]        j_ff, j_in;
   logic [VW-1:0]        rem_ff, rem_in;
   logic [VW-1:0]        root_ff, root_in;
   logic [VW-1:0]        bit_ff, bit_in;
   logic                 ans_ff, ans_in;
   logic [SQW-1:0]       sq;
   logic [VW-1:0]        trial;
   logic                 wr_en;
   logic [ROOT_BITS-1:0] wr_addr;
   logic                 wr_data;
   logic                 rd_en;
   logic [ROOT_BITS-1:0] rd_addr;
   logic [0:0]           rd_data;
   logic                 in_range;

   assign sq    = SQW'(i_ff) * SQW'(i_ff);
   assign trial = root_ff + bit_ff;
   assign in_range = (root_ff[VW-1:ROOT_BITS] == '0);

   always_comb begin
      fill_addr_in = fill_addr_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      ans_in  = ans_ff;
      if (cmd.fill_step) begin
         fill_addr_in = fill_addr_ff + ROOT_BITS'(1);
      end
      if (cmd.scan_init) begin
         i_in = IW'(2);
      end
      if (cmd.scan_next) begin
         i_in = i_ff + IW'(1);
      end
      if (cmd.mark_init) begin
         j_in = JW'(sq);
      end
      if (cmd.mark_step) begin
         j_in = j_ff + JW'(i_ff);
      end
      if (cmd.root_load) begin
         rem_in  = value;
         root_in = '0;
         bit_in  = psq_pkg::ROOT_BIT_INIT;
      end
      if (cmd.root_step) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
      if (cmd.rsp_load) begin
         ans_in = (rem_ff == '0) && in_range && rd_data[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_addr_ff <= '0;
      end else begin
         fill_addr_ff <= fill_addr_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      ans_ff  <= ans_in;
   end

   // one write port shared by fill and marking, one read port by scan and lookup
   always_comb begin
      wr_en   = cmd.fill_step || cmd.mark_step;
      wr_addr = cmd.mark_step ? j_ff[ROOT_BITS-1:0] : fill_addr_ff;
      wr_data = cmd.mark_step ? 1'b0 : (fill_addr_ff > ROOT_BITS'(1));
      rd_en   = cmd.scan_read || cmd.look_read;
      rd_addr = cmd.scan_read ? ROOT_BITS'(i_ff) : root_ff[ROOT_BITS-1:0];
   end

   psq_ram #(
      .WIDTH(1),
      .DEPTH(1 << ROOT_BITS)
   ) u_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      sts.fill_last = &fill_addr_ff;
      sts.scan_end  = |sq[SQW-1:ROOT_BITS];
      sts.mark_end  = j_ff[ROOT_BITS];
      sts.root_last = bit_ff[0];
      sts.map_bit   = rd_data[0];
   end

   assign is_prime_square = ans_ff;

   a_mark_in_map: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_step |-> !j_ff[ROOT_BITS] && (j_ff >= JW'(4)))
      else $error("marking write outside the map");

   a_scan_from_two: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_read |-> (i_ff >= IW'(2)) && !sts.scan_end)
      else $error("scan read of a root below two or past the bound");

endmodule
`default_nettype wire

[hw/rtl/psq_ctrl.sv]
// controller: sieve build sequence, root iterations and beat handshake
`timescale 1ns / 1ps
`default_nettype none
module psq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output psq_pkg::cmd_type         cmd,
   input  wire psq_pkg::status_type sts
);

   typedef enum logic [2:0] {
      ST_FILL,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_MARK,
      ST_IDLE,
      ST_ROOT,
      ST_LOOK,
      ST_CAP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_last) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (sts.scan_end) begin
               state_in = ST_IDLE;
            end else begin
               cmd.scan_read = 1'b1;
               state_in      = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (sts.map_bit) begin
               cmd.mark_init = 1'b1;
               state_in      = ST_MARK;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_MARK: begin
            if (sts.mark_end) begin
               cmd.scan_next = 1'b1;
               state_in      = ST_SCAN_RD;
            end else begin
               cmd.mark_step = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.root_load = 1'b1;
               state_in      = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (sts.root_last) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.look_read = 1'b1;
            state_in      = ST_CAP;
         end
         ST_CAP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.fill_step, cmd.mark_step, cmd.root_step, cmd.rsp_load}))
      else $error("conflicting datapath commands");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.rsp_load))
      else $error("result beat without a captured answer");

   a_no_req_in_build: assert property (@(posedge clock) disable iff (reset)
      (cmd.fill_step || cmd.mark_step || cmd.scan_read) |-> !req_ready)
      else $error("request taken while the map is being built");

endmodule
`default_nettype wire

[hw/rtl/prime_square_test_core.sv]
// top level of the prime square test block
//
//   channel | ports                           | direction
//   req     | req_valid req_ready req_value   | in
//   rsp     | rsp_valid rsp_ready rsp_is_prime_square | out
//
// after reset the prime map is built: a fill pass over all 2^ROOT_BITS entries, then
// marking writes for the multiples of each prime root found by the scan; req_ready is low
// each item then goes through 16 root iterations, one map read, one capture
// and the idle state that accepts the beat
// a held result beat does not block the next accept; capture waits for rsp_ready
`timescale 1ns / 1ps
`default_nettype none
module prime_square_test_core #(
   parameter int ROOT_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [psq_pkg::VALUE_W-1:0] req_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_is_prime_square
);

   psq_pkg::cmd_type    cmd;
   psq_pkg::status_type sts;

   psq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .sts      (sts)
   );

   psq_datapath #(
      .ROOT_BITS(ROOT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .value          (req_value),
      .sts            (sts),
      .is_prime_square(rsp_is_prime_square)
   );

endmodule
`default_nettype wire

[sim/tb_prime_square_test_core.sv]
// testbench for prime_square_test_core: value beats checked against a sieve-based predictor
`timescale 1ns / 1ps

class prime_square_scoreboard #(int ROOT_BITS = 16);
   localparam int unsigned MAP_DEPTH = 1 << ROOT_BITS;

   bit root_is_prime[MAP_DEPTH];
   bit pending_answers[$];
   int errors;

   function new();
      int unsigned i;
      int unsigned j;
      errors = 0;
      foreach (root_is_prime[k]) root_is_prime[k] = 1'b1;
      root_is_prime[0] = 1'b0;
      root_is_prime[1] = 1'b0;
      for (i = 2; i * i < MAP_DEPTH; i++) begin
         if (root_is_prime[i]) begin
            for (j = i * i; j < MAP_DEPTH; j += i) root_is_prime[j] = 1'b0;
         end
      end
   endfunction

   // largest r with r*r <= v
   function longint unsigned floor_root(logic [31:0] v);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      lo = 0;
      hi = 65535;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid <= longint'(v)) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function bit square_of_prime(logic [31:0] v);
      longint unsigned r;
      r = floor_root(v);
      if (r * r != longint'(v)) return 1'b0;
      if (r >= MAP_DEPTH) return 1'b0;
      return root_is_prime[r];
   endfunction

   function void note_value(logic [31:0] v);
      pending_answers = {pending_answers, square_of_prime(v)};
   endfunction

   function void check_answer(logic got);
      bit want;
      if (pending_answers.size() == 0) begin
         $error("is_prime_square: beat with nothing expected, expected none, actual %0b", got);
         errors++;
      end else begin
         want = pending_answers.pop_front();
         if (got !== want) begin
            $error("is_prime_square: expected %0b, actual %0b", want, got);
            errors++;
         end
      end
   endfunction

   function int pending_count();
      return pending_answers.size();
   endfunction
endclass

module tb_prime_square_test_core;
   localparam int ROOT_BITS = 16;
   localparam int WATCHDOG_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 1400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_is_prime_square;

   bit gaps_on = 1'b1;
   int stall_cycles = 0;

   prime_square_scoreboard #(ROOT_BITS) sb;

   prime_square_test_core #(
      .ROOT_BITS(ROOT_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_prime_square(rsp_is_prime_square)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_answer(rsp_is_prime_square);
         rsp_ready <= !gaps_on || ($urandom_range(0, 99) >= 33);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_value(input logic [31:0] v);
      if (gaps_on && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      sb.note_value(v);
   endtask

   task automatic drain_answers();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_count() != 0);
   endtask

   function automatic int unsigned pick_prime_root(bit low_range);
      int unsigned r;
      do begin
         r = low_range ? $urandom_range(2, 300) : $urandom_range(2, 65535);
      end while (!sb.root_is_prime[r]);
      return r;
   endfunction

   function automatic logic [31:0] random_value();
      int unsigned r;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: begin
            r = pick_prime_root($urandom_range(0, 1) == 1);
            return r * r;
         end
         3, 4: begin
            r = $urandom_range(0, 65535);
            return r * r;
         end
         5: begin
            r = $urandom_range(0, 65535);
            return $urandom_range(0, 1) ? r * r + 1 : r * r - 1;
         end
         6: return $urandom_range(0, 1000);
         default: return $urandom;
      endcase
   endfunction

   logic [31:0] directed_values[] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd8, 32'd9, 32'd16, 32'd25,
      32'd49, 32'd121, 32'd169, 32'd289, 32'd65025, 32'd65536,
      32'd1072497001, 32'd4293001441, 32'd4293001440, 32'd4293001442,
      32'd4294836225, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
   };

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_values[i]) send_value(directed_values[i]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) drain_answers();
         gaps_on = !(n >= 700 && n < 1000);
         send_value(random_value());
      end
      gaps_on = 1'b1;
      req_valid <= 1'b0;

      while (sb.pending_count() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (sb.errors == 0 && sb.pending_count() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
